/* sv/hhp_pkg.sv */
// shared types, constants and codes of the http header parser
`default_nettype none

package hhp_pkg;

	// field length counter width, fixed field limits
	localparam int LENGTH_BITS_DEF = 13;
	localparam int METHOD_MAX      = 8;
	localparam int VERSION_MAX     = 8;
	localparam int CODE_MAX        = 3;
	localparam int REASON_MAX      = 128;

	// configuration register map
	localparam int LIMIT_W  = 12;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_URI_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NAME_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT = 2'd2;
	localparam logic [LIMIT_W-1:0] URI_LIMIT_RST   = 12'd2048;
	localparam logic [LIMIT_W-1:0] NAME_LIMIT_RST  = 12'd256;
	localparam logic [LIMIT_W-1:0] VALUE_LIMIT_RST = 12'd2048;

	// item action codes
	typedef enum logic [1:0] {
		ACT_DATA = 2'd0,
		ACT_REQ  = 2'd1,
		ACT_RSP  = 2'd2
	} action_t;

	// field kinds
	typedef enum logic [2:0] {
		K_NONE    = 3'd0,
		K_METHOD  = 3'd1,
		K_URI     = 3'd2,
		K_VERSION = 3'd3,
		K_CODE    = 3'd4,
		K_REASON  = 3'd5,
		K_NAME    = 3'd6,
		K_VALUE   = 3'd7
	} kind_t;

	// error codes
	typedef enum logic [4:0] {
		E_NONE          = 5'd0,
		E_METHOD_LONG   = 5'd1,
		E_METHOD_CHAR   = 5'd2,
		E_URI_LONG      = 5'd3,
		E_REQ_VER_LONG  = 5'd4,
		E_REQ_VER_CHAR  = 5'd5,
		E_LF_EXPECTED   = 5'd6,
		E_RSP_VER_LONG  = 5'd7,
		E_CODE_LONG     = 5'd8,
		E_CODE_CHAR     = 5'd9,
		E_REASON_LONG   = 5'd10,
		E_NAME_CHAR     = 5'd11,
		E_NAME_LONG     = 5'd12,
		E_VALUE_CR      = 5'd13,
		E_VALUE_LONG    = 5'd14,
		E_NOT_PARSING   = 5'd15
	} err_t;

	// character classes of one byte
	typedef struct packed {
		logic upper;
		logic digit;
		logic token;
		logic ver;
		logic sp;
		logic cr;
		logic lf;
		logic colon;
	} char_class_t;

	// result flags of one byte
	typedef struct packed {
		kind_t kind;
		logic  app;
		logic  beg;
		logic  ends;
		logic  done;
		logic  err;
		err_t  code;
	} result_t;

	// configured length limits
	typedef struct packed {
		logic [LIMIT_W-1:0] uri;
		logic [LIMIT_W-1:0] name;
		logic [LIMIT_W-1:0] value;
	} limits_t;

endpackage

`default_nettype wire

/* sv/hhp_class.sv */
// character classifier for the http header parser
`default_nettype none

module hhp_class (
	input  wire logic [7:0]          c,
	output hhp_pkg::char_class_t     cls
);
	import hhp_pkg::*;

	// upper, digit, token, version and single character classes
	always_comb begin
		cls.upper = (c >= 8'h41) && (c <= 8'h5a);
		cls.digit = (c >= 8'h30) && (c <= 8'h39);
		// printable ascii minus the separators
		cls.token = (c >= 8'd33) && (c <= 8'd126) &&
			!(c inside {8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a,
				8'h5c, 8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d});
		// H T P / . and digits
		cls.ver   = (c inside {8'h48, 8'h54, 8'h50, 8'h2f, 8'h2e}) || cls.digit;
		cls.sp    = (c == 8'h20);
		cls.cr    = (c == 8'h0d);
		cls.lf    = (c == 8'h0a);
		cls.colon = (c == 8'h3a);
	end

endmodule

`default_nettype wire

/* sv/hhp_fsm.sv */
// parse state and field length registers with the per-byte next-state logic
`default_nettype none

module hhp_fsm #(
	parameter int LENGTH_BITS = hhp_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step_en,
	input  wire logic [1:0]           action,
	input  hhp_pkg::char_class_t      cls,
	input  hhp_pkg::limits_t          limits,
	output hhp_pkg::result_t          res
);
	import hhp_pkg::*;

	localparam int CW = (LENGTH_BITS > LIMIT_W) ? LENGTH_BITS : LIMIT_W;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	typedef enum logic [19:0] {
		ST_ERROR      = 20'h00001,
		ST_METHOD     = 20'h00002,
		ST_METHOD_SP  = 20'h00004,
		ST_URI        = 20'h00008,
		ST_URI_SP     = 20'h00010,
		ST_REQ_VER    = 20'h00020,
		ST_REQ_LF     = 20'h00040,
		ST_RSP_VER    = 20'h00080,
		ST_RSP_VER_SP = 20'h00100,
		ST_CODE       = 20'h00200,
		ST_CODE_SP    = 20'h00400,
		ST_REASON     = 20'h00800,
		ST_RSP_LF     = 20'h01000,
		ST_HDR_START  = 20'h02000,
		ST_HDR_NAME   = 20'h04000,
		ST_HDR_SP     = 20'h08000,
		ST_HDR_VALUE  = 20'h10000,
		ST_HDR_LF     = 20'h20000,
		ST_END_LF     = 20'h40000,
		ST_BODY       = 20'h80000
	} state_t;

	state_t                  state_q, state_d;
	logic [LENGTH_BITS-1:0]  len_q, len_d;
	logic                    len_zero;
	logic [LENGTH_BITS-1:0]  len_inc;
	logic [CW-1:0]           len_w;
	logic                    gt_method, gt_version, gt_code, gt_reason, gt_uri;
	logic                    lt_name, lt_value;

	// length compares and saturating increment
	always_comb begin
		len_zero   = (len_q == '0);
		len_inc    = len_q + LENGTH_BITS'(len_q != LEN_MAX);
		len_w      = CW'(len_q);
		gt_method  = len_w > CW'(METHOD_MAX);
		gt_version = len_w > CW'(VERSION_MAX);
		gt_code    = len_w > CW'(CODE_MAX);
		gt_reason  = len_w > CW'(REASON_MAX);
		gt_uri     = len_w > CW'(limits.uri);
		lt_name    = len_w < CW'(limits.name);
		lt_value   = len_w < CW'(limits.value);
	end

	// next state, next length and result of the current byte
	always_comb begin
		state_d = state_q;
		len_d   = len_q;
		res     = '0;
		res.kind = K_NONE;
		res.code = E_NONE;
		case (action)
			ACT_REQ: begin
				state_d = ST_METHOD;
				len_d   = '0;
			end
			ACT_RSP: begin
				state_d = ST_RSP_VER;
				len_d   = '0;
			end
			ACT_DATA: begin
				case (state_q)
					ST_METHOD: begin
						res.kind = K_METHOD;
						if (gt_method) begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_METHOD_LONG;
						end else if (cls.sp) begin
							res.ends = 1'b1; state_d = ST_METHOD_SP;
						end else if (cls.upper) begin
							res.app = 1'b1; res.beg = len_zero; len_d = len_inc;
						end else begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_METHOD_CHAR;
						end
					end
					ST_METHOD_SP: begin
						if (!cls.sp) begin
							res.kind = K_URI; res.app = 1'b1; res.beg = 1'b1;
							len_d = LENGTH_BITS'(1); state_d = ST_URI;
						end
					end
					ST_URI: begin
						res.kind = K_URI;
						if (gt_uri) begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_URI_LONG;
						end else if (cls.sp) begin
							res.ends = 1'b1; state_d = ST_URI_SP;
						end else begin
							res.app = 1'b1; res.beg = len_zero; len_d = len_inc;
						end
					end
					ST_URI_SP: begin
						if (!cls.sp) begin
							res.kind = K_VERSION; res.app = 1'b1; res.beg = 1'b1;
							len_d = LENGTH_BITS'(1); state_d = ST_REQ_VER;
						end
					end
					ST_REQ_VER: begin
						res.kind = K_VERSION;
						if (cls.cr) begin
							res.ends = 1'b1; state_d = ST_REQ_LF;
						end else if (gt_version) begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_REQ_VER_LONG;
						end else if (!cls.ver) begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_REQ_VER_CHAR;
						end else begin
							res.app = 1'b1; res.beg = len_zero; len_d = len_inc;
						end
					end
					ST_REQ_LF, ST_RSP_LF, ST_HDR_LF: begin
						if (cls.lf) begin
							state_d = ST_HDR_START;
						end else begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_LF_EXPECTED;
						end
					end
					ST_RSP_VER: begin
						res.kind = K_VERSION;
						if (gt_version) begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_RSP_VER_LONG;
						end else if (cls.sp) begin
							res.ends = 1'b1; state_d = ST_RSP_VER_SP;
						end else begin
							res.app = 1'b1; res.beg = len_zero; len_d = len_inc;
						end
					end
					ST_RSP_VER_SP: begin
						if (!cls.sp) begin
							res.kind = K_CODE; res.app = 1'b1; res.beg = 1'b1;
							len_d = LENGTH_BITS'(1); state_d = ST_CODE;
						end
					end
					ST_CODE: begin
						res.kind = K_CODE;
						if (gt_code) begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_CODE_LONG;
						end else if (cls.sp) begin
							res.ends = 1'b1; state_d = ST_CODE_SP;
						end else if (cls.digit) begin
							res.app = 1'b1; res.beg = len_zero; len_d = len_inc;
						end else begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_CODE_CHAR;
						end
					end
					ST_CODE_SP: begin
						if (!cls.sp) begin
							res.kind = K_REASON; res.app = 1'b1; res.beg = 1'b1;
							len_d = LENGTH_BITS'(1); state_d = ST_REASON;
						end
					end
					ST_REASON: begin
						res.kind = K_REASON;
						if (gt_reason) begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_REASON_LONG;
						end else if (cls.cr) begin
							res.ends = 1'b1; state_d = ST_RSP_LF;
						end else begin
							res.app = 1'b1; res.beg = len_zero; len_d = len_inc;
						end
					end
					ST_HDR_START: begin
						if (cls.cr) begin
							state_d = ST_END_LF;
						end else if (cls.token) begin
							res.kind = K_NAME; res.app = 1'b1; res.beg = 1'b1;
							len_d = LENGTH_BITS'(1); state_d = ST_HDR_NAME;
						end else begin
							res.kind = K_NAME;
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_NAME_CHAR;
						end
					end
					ST_HDR_NAME: begin
						res.kind = K_NAME;
						if (cls.colon) begin
							res.ends = 1'b1; state_d = ST_HDR_SP;
						end else if (!cls.token) begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_NAME_CHAR;
						end else if (lt_name) begin
							res.app = 1'b1; res.beg = len_zero; len_d = len_inc;
						end else begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_NAME_LONG;
						end
					end
					ST_HDR_SP: begin
						if (cls.cr) begin
							res.kind = K_VALUE;
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_VALUE_CR;
						end else if (!cls.sp) begin
							res.kind = K_VALUE; res.app = 1'b1; res.beg = 1'b1;
							len_d = LENGTH_BITS'(1); state_d = ST_HDR_VALUE;
						end
					end
					ST_HDR_VALUE: begin
						res.kind = K_VALUE;
						if (cls.cr) begin
							res.ends = 1'b1; state_d = ST_HDR_LF;
						end else if (lt_value) begin
							res.app = 1'b1; res.beg = len_zero; len_d = len_inc;
						end else begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_VALUE_LONG;
						end
					end
					ST_END_LF: begin
						if (cls.lf) begin
							state_d = ST_BODY; res.done = 1'b1;
						end else begin
							state_d = ST_ERROR; res.err = 1'b1; res.code = E_LF_EXPECTED;
						end
					end
					// error state and end of headers: bytes are not expected
					default: begin
						state_d = ST_ERROR; res.err = 1'b1; res.code = E_NOT_PARSING;
					end
				endcase
			end
			default: ;
		endcase
	end

	// state and length registers, advanced once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ERROR;
			len_q   <= '0;
		end else if (step_en) begin
			state_q <= state_d;
			len_q   <= len_d;
		end
	end

endmodule

`default_nettype wire

/* sv/http_header_parser.sv */
// http header parser top level: input stage, limit registers, parser and result register
// a byte passes through the input stage and then the result register
// throughput: one byte per clock if out_ready is high; state and field length step per byte
// while a result waits for out_ready the input stage holds one more byte, then in_ready drops
// reset: parser in the error state awaiting a start item, field length zero,
// limits at 2048 / 256 / 2048, both stages empty
`default_nettype none

module http_header_parser #(
	parameter int LENGTH_BITS = hhp_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    action,
	input  wire logic [7:0]                    data_byte,
	// configuration channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [hhp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hhp_pkg::LIMIT_W-1:0]   cfg_data,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [2:0]                         field_kind,
	output logic [7:0]                         out_byte,
	output logic                               byte_appended,
	output logic                               field_begins,
	output logic                               field_ends,
	output logic                               headers_done,
	output logic                               error_flag,
	output logic [4:0]                         error_code
);
	import hhp_pkg::*;

	logic          valid_s1;
	logic [1:0]    action_s1;
	logic [7:0]    byte_s1;
	logic          step_s1;
	limits_t       limits_q;
	char_class_t   cls;
	result_t       res;
	result_t       res_q;
	logic [7:0]    byte_q;
	logic          out_valid_q;

	// handshakes: the input stage moves when the result register is free or drains
	assign step_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || step_s1;
	assign cfg_ready = 1'b1;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			byte_s1   <= data_byte;
		end
	end

	// limit registers, written by a configuration transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.uri   <= URI_LIMIT_RST;
			limits_q.name  <= NAME_LIMIT_RST;
			limits_q.value <= VALUE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_URI_LIMIT:   limits_q.uri   <= cfg_data;
				CFG_NAME_LIMIT:  limits_q.name  <= cfg_data;
				CFG_VALUE_LIMIT: limits_q.value <= cfg_data;
				default: ;
			endcase
		end
	end

	hhp_class u_class (
		.c   (byte_s1),
		.cls (cls)
	);

	hhp_fsm #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_s1),
		.action  (action_s1),
		.cls     (cls),
		.limits  (limits_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_s1) begin
			res_q  <= res;
			byte_q <= (action_s1 == ACT_DATA) ? byte_s1 : 8'd0;
		end
	end

	// result ports
	assign out_valid     = out_valid_q;
	assign field_kind    = res_q.kind;
	assign out_byte      = byte_q;
	assign byte_appended = res_q.app;
	assign field_begins  = res_q.beg;
	assign field_ends    = res_q.ends;
	assign headers_done  = res_q.done;
	assign error_flag    = res_q.err;
	assign error_code    = res_q.code;

	// an error always carries a code, and a clean byte never does
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((error_flag == 1'b1) == (error_code != E_NONE)))
		else $error("error flag and error code disagree");

	// a field begins only on an appended byte that belongs to a field
	a_app_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_begins |-> byte_appended && (field_kind != K_NONE))
		else $error("field begin without an appended byte");

	// a byte does at most one thing: append, close, finish or fail
	a_one_act: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({byte_appended, field_ends, headers_done, error_flag}))
		else $error("more than one action on a byte");

	// a start item gives an all-zero result
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		step_s1 && (action_s1 != ACT_DATA) |=> (out_byte == 8'd0) && !error_flag
			&& (field_kind == K_NONE))
		else $error("start item gave a nonzero result");

endmodule

`default_nettype wire
